[hw/rtl/tioc_pkg.sv]
// Shared types and codes for the tiled interval overlap counter.
package tioc_pkg;

	typedef enum logic [2:0] {
		FUNC_LOAD    = 3'd0,
		FUNC_QUERY   = 3'd1,
		FUNC_READ    = 3'd2,
		FUNC_CLR_CNT = 3'd3,
		FUNC_CLR_IDX = 3'd4
	} func_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLR_CNT,
		ST_CLR_IDX,
		ST_LOAD_RD,
		ST_LOAD_WR,
		ST_READ_RD,
		ST_READ_OUT,
		ST_DIV1,
		ST_DIV2,
		ST_TILE,
		ST_TILE_RD,
		ST_TILE_CHK,
		ST_BS_RD,
		ST_BS_CHK,
		ST_SC_RD,
		ST_SC_CHK,
		ST_SC_CNT,
		ST_SC_WR,
		ST_NEXT,
		ST_DONE
	} state_t;

	localparam int unsigned COORD_W = 31;
	localparam int unsigned HIT_W   = 13;
	localparam int unsigned CNT_W   = 32;

endpackage

[hw/rtl/tiled_interval_overlap_counter_unit.sv]
// Top level of the tiled interval overlap counter: index store, query sequencer, counters.
//
//  channel   signals                                      direction
//  command   start, busy, func, chrom_id, tile_number,    in (busy out)
//            region_start, region_end, source_index
//  config    cfg_valid, cfg_ready, cfg_data               in (cfg_ready out)
//  result    done, status, hit_count, counter_value       out
//
// A load reads the tile slot and then writes the record; a counter read reads the
// counter and then returns it. A query runs two 31-step divisions on the shared
// subtract unit, then per tile a binary search (one memory read and compare per step)
// and a downward scan that reads and checks each record, and on a hit also counts it.
// Clearing the counters sweeps NUM_SOURCES entries; clearing the index sweeps the tile
// table of MAX_CHROMS*MAX_TILES slots; after reset both sweeps run with busy high and
// no result. The receiver cannot stall: done is high for one cycle with the result.
module tiled_interval_overlap_counter_unit #(
	parameter int unsigned MAX_CHROMS  = 32,
	parameter int unsigned MAX_TILES   = 256,
	parameter int unsigned MAX_RECORDS = 4096,
	parameter int unsigned NUM_SOURCES = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [2:0]                func,
	input  logic [4:0]                chrom_id,
	input  logic [7:0]                tile_number,
	input  logic [30:0]               region_start,
	input  logic [30:0]               region_end,
	input  logic [7:0]                source_index,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [30:0]               cfg_data,
	output logic                      done,
	output logic                      status,
	output logic [12:0]               hit_count,
	output logic [31:0]               counter_value
);
	import tioc_pkg::*;

	localparam int unsigned CW   = (MAX_CHROMS > 1) ? $clog2(MAX_CHROMS) : 1;
	localparam int unsigned TW   = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
	localparam int unsigned SLOTS = MAX_CHROMS * MAX_TILES;
	localparam int unsigned SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned RW   = $clog2(MAX_RECORDS);
	localparam int unsigned FW   = $clog2(MAX_RECORDS + 1);
	localparam int unsigned NW   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int unsigned QW   = (NUM_SOURCES > 256) ? NW : 8;
	localparam int unsigned XW   = (SW > NW) ? SW : NW;

	// memories
	logic [COORD_W-1:0] rec_start_mem [MAX_RECORDS];
	logic [COORD_W-1:0] rec_end_mem   [MAX_RECORDS];
	logic [NW-1:0]      rec_src_mem   [MAX_RECORDS];
	logic [RW-1:0]      tfirst_mem    [SLOTS];
	logic [FW-1:0]      tcount_mem    [SLOTS];
	logic [CNT_W-1:0]   hit_mem       [NUM_SOURCES];

	state_t state_q, state_d;

	logic [COORD_W-1:0] width_q;
	logic [FW-1:0]      fill_q;
	logic [CW+TW+COORD_W-1:0] key_q;
	logic               key_vld_q;
	logic               init_q;

	// latched command
	logic [2:0]         func_q;
	logic [4:0]         chrom_q;
	logic [7:0]         tile_q;
	logic [COORD_W-1:0] qs_q, qe_q;
	logic [7:0]         src_q;

	// sweep / divider / search registers
	logic [XW-1:0]      sweep_q;
	logic [5:0]         step_q;
	logic [COORD_W-1:0] rem_q, quo_q;
	logic [COORD_W-1:0] n1_q, n2_q, t_q;
	logic               n2_ovf_q;
	logic [FW-1:0]      first_q, cnt_q;
	logic [FW-1:0]      lo_q, hi_q, idx_q;
	logic [31:0]        lower_q;
	logic [HIT_W-1:0]   found_q;
	logic               status_q;
	logic [CNT_W-1:0]   value_q;

	// registered memory reads
	logic [RW-1:0]      tfirst_rd_q;
	logic [FW-1:0]      tcount_rd_q;
	logic [COORD_W-1:0] rs_rd_q, re_rd_q;
	logic [NW-1:0]      src_rd_q;
	logic [CNT_W-1:0]   hit_rd_q;

	logic [COORD_W-1:0] w_eff;
	assign w_eff = (width_q == '0) ? COORD_W'(1) : width_q;

	// shared subtract unit of the restoring divider
	logic [COORD_W:0]   div_trial;
	logic [COORD_W:0]   div_shift;
	logic [COORD_W-1:0] div_dividend;
	assign div_dividend = (state_q == ST_DIV1) ? qs_q : (qe_q - COORD_W'(1));
	assign div_shift = {rem_q, div_dividend[COORD_W-1-step_q[4:0]]};
	assign div_trial = div_shift - {1'b0, w_eff};

	// slot address
	logic [CW+TW-1:0] slot_cur;
	assign slot_cur = {chrom_q[CW-1:0], t_q[TW-1:0]};
	logic [CW+TW-1:0] slot_ld;
	assign slot_ld  = {chrom_q[CW-1:0], tile_q[TW-1:0]};

	logic [CW+TW+COORD_W-1:0] ld_key;
	assign ld_key = {chrom_q[CW-1:0], tile_q[TW-1:0], qs_q};

	logic ld_reject;
	assign ld_reject = (fill_q >= FW'(MAX_RECORDS)) || (32'(chrom_q) >= MAX_CHROMS)
		|| (32'(tile_q) >= MAX_TILES) || (32'(src_q) >= NUM_SOURCES)
		|| (key_vld_q && (ld_key < key_q));

	logic [FW-1:0] mid;
	assign mid = FW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

	logic [RW-1:0] idx_addr;
	assign idx_addr = (state_q == ST_BS_RD) ? mid[RW-1:0] : idx_q[RW-1:0];

	logic [63:0] lower_prod;
	assign lower_prod = 64'(w_eff) * 64'(t_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (func)
						FUNC_LOAD:    state_d = ST_LOAD_RD;
						FUNC_QUERY:   state_d = ST_DIV1;
						FUNC_READ:    state_d = ST_READ_RD;
						FUNC_CLR_CNT: state_d = ST_CLR_CNT;
						FUNC_CLR_IDX: state_d = ST_CLR_IDX;
						default:      state_d = ST_DONE;
					endcase
				end
			end
			// the sweeps after reset chain into each other and give no result
			ST_CLR_CNT: if (32'(sweep_q) == NUM_SOURCES - 1)
				state_d = init_q ? ST_CLR_IDX : ST_DONE;
			ST_CLR_IDX: if (32'(sweep_q) == SLOTS - 1)
				state_d = init_q ? ST_IDLE : ST_DONE;
			ST_LOAD_RD: state_d = ST_LOAD_WR;
			ST_LOAD_WR: state_d = ST_DONE;
			ST_READ_RD: state_d = ST_READ_OUT;
			ST_READ_OUT: state_d = ST_DONE;
			ST_DIV1: if (step_q == 6'(COORD_W - 1)) state_d = ST_DIV2;
			ST_DIV2: if (step_q == 6'(COORD_W - 1)) state_d = ST_TILE;
			ST_TILE: begin
				if ((32'(chrom_q) >= MAX_CHROMS) || (32'(n1_q) > MAX_TILES - 1))
					state_d = ST_DONE;
				else
					state_d = ST_TILE_RD;
			end
			ST_TILE_RD: state_d = ST_TILE_CHK;
			ST_TILE_CHK: state_d = (tcount_rd_q == '0) ? ST_NEXT : ST_BS_RD;
			ST_BS_RD: state_d = (lo_q == hi_q) ? ST_SC_RD : ST_BS_CHK;
			ST_BS_CHK: state_d = ST_BS_RD;
			ST_SC_RD: state_d = (idx_q == first_q) ? ST_NEXT : ST_SC_CHK;
			ST_SC_CHK: begin
				if ((32'(rs_rd_q) >= lower_q) && (re_rd_q > qs_q))
					state_d = ST_SC_CNT;
				else
					state_d = ST_SC_RD;
			end
			ST_SC_CNT: state_d = ST_SC_WR;
			ST_SC_WR: state_d = ST_SC_RD;
			ST_NEXT: state_d = (t_q >= n2_q) ? ST_DONE : ST_TILE_RD;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy          = (state_q != ST_IDLE);
		cfg_ready     = (state_q == ST_IDLE);
		done          = (state_q == ST_DONE);
		status        = status_q;
		hit_count     = found_q;
		counter_value = value_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR_CNT;
			init_q    <= 1'b1;
			width_q   <= COORD_W'(16384);
			fill_q    <= '0;
			key_vld_q <= 1'b0;
			key_q     <= '0;
			sweep_q   <= '0;
			step_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) width_q <= cfg_data;
			if (state_q == ST_CLR_IDX && state_d != ST_CLR_IDX) init_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					sweep_q <= '0;
					step_q  <= '0;
				end
				ST_CLR_CNT, ST_CLR_IDX: sweep_q <= (state_d != state_q) ? '0
					: sweep_q + XW'(1);
				ST_LOAD_WR: begin
					if (!ld_reject) begin
						fill_q    <= fill_q + FW'(1);
						key_q     <= ld_key;
						key_vld_q <= 1'b1;
					end
				end
				ST_DIV1, ST_DIV2: step_q <= (step_q == 6'(COORD_W - 1)) ? '0 : step_q + 6'd1;
				default: ;
			endcase
			if (state_q == ST_CLR_IDX) begin
				fill_q    <= '0;
				key_vld_q <= 1'b0;
				key_q     <= '0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				func_q   <= func;
				chrom_q  <= chrom_id;
				tile_q   <= tile_number;
				qs_q     <= region_start;
				qe_q     <= region_end;
				src_q    <= source_index;
				status_q <= 1'b0;
				found_q  <= '0;
				value_q  <= '0;
				rem_q    <= '0;
				quo_q    <= '0;
			end
			ST_LOAD_WR: status_q <= ld_reject;
			ST_READ_OUT: value_q <= (32'(src_q) < NUM_SOURCES) ? hit_rd_q : '0;
			ST_DIV1, ST_DIV2: begin
				if (!div_trial[COORD_W]) begin
					rem_q <= div_trial[COORD_W-1:0];
					quo_q <= {quo_q[COORD_W-2:0], 1'b1};
				end else begin
					rem_q <= div_shift[COORD_W-1:0];
					quo_q <= {quo_q[COORD_W-2:0], 1'b0};
				end
				if (step_q == 6'(COORD_W - 1)) begin
					rem_q <= '0;
					quo_q <= '0;
					if (state_q == ST_DIV1) begin
						n1_q <= {quo_q[COORD_W-2:0], ~div_trial[COORD_W]};
					end else begin
						n2_q <= {quo_q[COORD_W-2:0], ~div_trial[COORD_W]};
					end
				end
			end
			ST_TILE: begin
				if (qe_q == '0) n2_q <= n1_q;
				else if (32'(n2_q) > MAX_TILES - 1) n2_q <= COORD_W'(MAX_TILES - 1);
				t_q     <= n1_q;
				lower_q <= '0;
			end
			ST_TILE_CHK: begin
				first_q <= FW'(tfirst_rd_q);
				cnt_q   <= tcount_rd_q;
				// search bounds: find count of records with start < qe
				lo_q    <= FW'(tfirst_rd_q);
				hi_q    <= FW'(tfirst_rd_q) + tcount_rd_q;
			end
			ST_BS_RD: idx_q <= lo_q;
			ST_BS_CHK: begin
				if (rs_rd_q < qe_q) lo_q <= mid + FW'(1);
				else hi_q <= mid;
			end
			ST_SC_RD: idx_q <= idx_q - FW'(1);
			ST_SC_CHK: begin
				if ((32'(rs_rd_q) >= lower_q) && (re_rd_q > qs_q)
					&& found_q != '1) found_q <= found_q + HIT_W'(1);
			end
			ST_NEXT: begin
				t_q     <= t_q + COORD_W'(1);
				lower_q <= lower_prod[31:0] + 32'(w_eff);
			end
			default: ;
		endcase
	end

	// memory ports
	always_ff @(posedge clk) begin
		tfirst_rd_q <= tfirst_mem[(state_q == ST_LOAD_RD) ? slot_ld[SW-1:0] : slot_cur[SW-1:0]];
		tcount_rd_q <= tcount_mem[(state_q == ST_LOAD_RD) ? slot_ld[SW-1:0] : slot_cur[SW-1:0]];
		if (state_q == ST_CLR_IDX) tcount_mem[sweep_q[SW-1:0]] <= '0;
		if (state_q == ST_LOAD_WR && !ld_reject) begin
			if (tcount_rd_q == '0) tfirst_mem[slot_ld[SW-1:0]] <= fill_q[RW-1:0];
			tcount_mem[slot_ld[SW-1:0]] <= tcount_rd_q + FW'(1);
		end
	end

	always_ff @(posedge clk) begin
		rs_rd_q  <= rec_start_mem[(state_q == ST_SC_RD) ? RW'(idx_q - FW'(1)) : idx_addr];
		re_rd_q  <= rec_end_mem[(state_q == ST_SC_RD) ? RW'(idx_q - FW'(1)) : idx_addr];
		src_rd_q <= rec_src_mem[(state_q == ST_SC_RD) ? RW'(idx_q - FW'(1)) : idx_addr];
		if (state_q == ST_LOAD_WR && !ld_reject) begin
			rec_start_mem[fill_q[RW-1:0]] <= qs_q;
			rec_end_mem[fill_q[RW-1:0]]   <= qe_q;
			rec_src_mem[fill_q[RW-1:0]]   <= src_q[NW-1:0];
		end
	end

	logic [NW-1:0] hit_addr;
	always_comb begin
		case (state_q)
			ST_CLR_CNT: hit_addr = sweep_q[NW-1:0];
			ST_READ_RD: hit_addr = src_q[NW-1:0];
			default:    hit_addr = src_rd_q;
		endcase
	end

	always_ff @(posedge clk) begin
		hit_rd_q <= hit_mem[hit_addr];
		if (state_q == ST_CLR_CNT) hit_mem[hit_addr] <= '0;
		if (state_q == ST_SC_WR && hit_rd_q != '1) hit_mem[src_rd_q] <= hit_rd_q + CNT_W'(1);
	end

	logic unused_ok;
	assign unused_ok = ^{cnt_q, func_q, QW};

endmodule
